[hdl/text_console_cursor_engine_unit_assert.svh]
// Assertion macros used by the text console executor.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define TCCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console check failed");

// Next-cycle implication, disabled in reset.
`define TCCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console check failed");

`endif

[hdl/tcce_pkg.sv]
// Types and constants shared across the text console engine.
package tcce_pkg;

  typedef enum logic [2:0] {
    MODE_PUT       = 3'd0,
    MODE_BACKSPACE = 3'd1,
    MODE_TAB       = 3'd2,
    MODE_CLEAR     = 3'd3,
    MODE_SCROLL    = 3'd4,
    MODE_READ      = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_TAB,
    OP_CLEAR,
    OP_SCROLL,
    OP_READ,
    OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_TAB,
    ST_CLEAR,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FILL,
    ST_READ_CAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t        op;
    logic       use_cursor;
    logic [4:0] row;
    logic [6:0] column;
    logic [7:0] char_code;
    logic [7:0] attribute;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam logic [7:0] NEWLINE_CODE       = 8'd10;
  localparam logic [7:0] SPACE_CODE         = 8'd32;
  localparam logic [7:0] SCROLL_FILL_ATTR   = 8'h07;
  localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;
  localparam int         TAB_CELLS          = 4;
  localparam int         TAB_CNT_W          = 2;
  localparam int         QUEUE_DEPTH        = 2;
  localparam int         QPTR_W             = 1;

endpackage

[hdl/tcce_chan_if.sv]
// Valid/ready channel interfaces for command beats and result beats.
interface tcce_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       use_cursor;
  logic [4:0] row;
  logic [6:0] column;
  logic [7:0] char_code;
  logic [7:0] attribute;

  modport source (output valid, mode, use_cursor, row, column, char_code, attribute,
                  input ready);
  modport sink (input valid, mode, use_cursor, row, column, char_code, attribute,
                output ready);
endinterface

interface tcce_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_cell;
  logic [7:0]  last_char;

  modport source (output valid, cursor_cell, last_char, input ready);
  modport sink (input valid, cursor_cell, last_char, output ready);
endinterface

[hdl/text_console_cursor_engine_unit.sv]
// Top level of the text console cursor engine: front end, queue and executor.
//
//   channel  dir  handshake      beat contents
//   in_ch    in   valid/ready    mode, use_cursor, row, column, char_code, attribute
//   out_ch   out  valid/ready    cursor_cell, last_char
//   cfg      in   cfg_we         cfg_data -> default attribute
//
// Put, newline, backspace and no-op pass through pop, execute and result in the executor;
// tab adds four cursor steps and read-last one registered store read.
// Clear walks the store one cell a cycle; scroll at a full cursor copies each cell
// with a read state and a write state, then fills the bottom row.
// After reset a clearing pass over every cell runs with in_ch.ready low.
// The two-entry queue keeps accepting until full while the executor works or out_ch stalls.
module text_console_cursor_engine_unit #(
  parameter int SCREEN_ROWS    = 25,
  parameter int SCREEN_COLUMNS = 80
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  tcce_in_if.sink    in_ch,
  tcce_out_if.source out_ch
);

  logic             push;
  logic             pop;
  logic             init_busy;
  tcce_pkg::entry_t push_data;
  tcce_pkg::entry_t pop_data;
  tcce_pkg::qstat_t q_stat;

  tcce_front #(
    .SCREEN_ROWS    (SCREEN_ROWS),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_front (
    .in_ch     (in_ch),
    .init_busy (init_busy),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  tcce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  tcce_back #(
    .SCREEN_ROWS    (SCREEN_ROWS),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_data    (pop_data),
    .q_pop     (pop),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

[hdl/tcce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

[hdl/tcce_front.sv]
// Command front end: takes input beats, classifies them and pushes queue entries.
module tcce_front #(
  parameter int SCREEN_ROWS    = 25,
  parameter int SCREEN_COLUMNS = 80
) (
  tcce_in_if.sink          in_ch,
  input  logic             init_busy,
  input  tcce_pkg::qstat_t q_stat,
  output logic             push,
  output tcce_pkg::entry_t push_data
);

  logic off_screen;
  tcce_pkg::op_t op;

  // explicit put positions outside the screen turn into no-ops, newline included
  assign off_screen = !in_ch.use_cursor &&
                      ((32'(in_ch.row) >= SCREEN_ROWS) ||
                       (32'(in_ch.column) >= SCREEN_COLUMNS));

  always_comb begin
    case (in_ch.mode)
      tcce_pkg::MODE_PUT: begin
        if (off_screen) begin
          op = tcce_pkg::OP_NOP;
        end else if (in_ch.char_code == tcce_pkg::NEWLINE_CODE) begin
          op = tcce_pkg::OP_NEWLINE;
        end else begin
          op = tcce_pkg::OP_PUT;
        end
      end
      tcce_pkg::MODE_BACKSPACE: op = tcce_pkg::OP_BACKSPACE;
      tcce_pkg::MODE_TAB:       op = tcce_pkg::OP_TAB;
      tcce_pkg::MODE_CLEAR:     op = tcce_pkg::OP_CLEAR;
      tcce_pkg::MODE_SCROLL:    op = tcce_pkg::OP_SCROLL;
      tcce_pkg::MODE_READ:      op = tcce_pkg::OP_READ;
      default:                  op = tcce_pkg::OP_NOP;
    endcase
  end

  assign in_ch.ready = !q_stat.full && !init_busy;
  assign push        = in_ch.valid && in_ch.ready;

  assign push_data.op         = op;
  assign push_data.use_cursor = in_ch.use_cursor;
  assign push_data.row        = in_ch.row;
  assign push_data.column     = in_ch.column;
  assign push_data.char_code  = in_ch.char_code;
  assign push_data.attribute  = in_ch.attribute;

endmodule

[hdl/tcce_queue.sv]
// Short command queue between the front end and the executor.
module tcce_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tcce_pkg::entry_t push_data,
  input  logic             pop,
  output tcce_pkg::entry_t pop_data,
  output tcce_pkg::qstat_t stat
);

  tcce_pkg::entry_t            q_r [tcce_pkg::QUEUE_DEPTH];
  logic [tcce_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tcce_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tcce_pkg::QPTR_W:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + tcce_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + tcce_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (tcce_pkg::QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (tcce_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = q_r[rd_ptr_r];
  assign stat.full  = (count_r == (tcce_pkg::QPTR_W + 1)'(tcce_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

[hdl/tcce_back.sv]
// Executor: cursor tracking, screen store sequencing and the result register.
`include "text_console_cursor_engine_unit_assert.svh"

module tcce_back #(
  parameter int SCREEN_ROWS    = 25,
  parameter int SCREEN_COLUMNS = 80
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  input  tcce_pkg::qstat_t q_stat,
  input  tcce_pkg::entry_t q_data,
  output logic             q_pop,
  output logic             init_busy,
  tcce_out_if.source       out_ch
);

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(SCREEN_ROWS + 1);
  localparam int CLW   = $clog2(SCREEN_COLUMNS + 1);
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam logic [CW-1:0]  CELLS_C      = CW'(CELLS);
  localparam logic [CW-1:0]  CELLS_M1_C   = CW'(CELLS - 1);
  localparam logic [CW-1:0]  COLS_C       = CW'(SCREEN_COLUMNS);
  localparam logic [CW-1:0]  LAST_START_C = CW'(CELLS - SCREEN_COLUMNS);
  localparam logic [RW-1:0]  ROWS_C       = RW'(SCREEN_ROWS);
  localparam logic [RW-1:0]  ROWS_M1_C    = RW'(SCREEN_ROWS - 1);
  localparam logic [CLW-1:0] COLS_M1_CL   = CLW'(SCREEN_COLUMNS - 1);
  localparam logic [15:0]    FILL_CELL    = {tcce_pkg::SCROLL_FILL_ATTR, 8'h00};
  localparam logic [tcce_pkg::TAB_CNT_W-1:0] TAB_LAST =
    tcce_pkg::TAB_CNT_W'(tcce_pkg::TAB_CELLS - 1);

  typedef struct packed {
    logic [CW-1:0]  idx;
    logic [RW-1:0]  row;
    logic [CLW-1:0] col;
  } pos_t;

  localparam pos_t HOME_POS     = '{idx: '0, row: '0, col: '0};
  localparam pos_t FULL_POS     = '{idx: CELLS_C, row: ROWS_C, col: '0};
  localparam pos_t LAST_ROW_POS = '{idx: LAST_START_C, row: ROWS_M1_C, col: '0};

  // one cell forward, saturating at the full position
  function automatic pos_t step_fwd(pos_t p);
    pos_t n;
    n = p;
    if (p.idx < CELLS_C) begin
      n.idx = p.idx + CW'(1);
      if (p.col == COLS_M1_CL) begin
        n.col = '0;
        n.row = p.row + RW'(1);
      end else begin
        n.col = p.col + CLW'(1);
      end
    end
    return n;
  endfunction

  function automatic pos_t step_back(pos_t p);
    pos_t n;
    n.idx = p.idx - CW'(1);
    if (p.col == '0) begin
      n.col = COLS_M1_CL;
      n.row = p.row - RW'(1);
    end else begin
      n.col = p.col - CLW'(1);
      n.row = p.row;
    end
    return n;
  endfunction

  // start of the following row, or full when there is none
  function automatic pos_t newline_pos(pos_t p);
    pos_t n;
    if (p.row >= ROWS_M1_C) begin
      n = FULL_POS;
    end else begin
      n.idx = p.idx - CW'(p.col) + COLS_C;
      n.row = p.row + RW'(1);
      n.col = '0;
    end
    return n;
  endfunction

  tcce_pkg::state_t state_r, state_nxt;
  pos_t             cur_r, cur_nxt;
  pos_t             tgt_r, tgt_nxt;
  pos_t             exp_pos;
  pos_t             bs_pos;
  tcce_pkg::op_t    op_r, op_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [7:0]       attr_r, attr_nxt;
  logic [7:0]       last_r, last_nxt;
  logic [7:0]       default_attr_r;
  logic [CW-1:0]    sweep_r, sweep_nxt;
  logic [CW-1:0]    sweep_inc;
  logic [CW-1:0]    copy_src;
  logic [CW-1:0]    cur_prev;
  logic [tcce_pkg::TAB_CNT_W-1:0] tab_cnt_r, tab_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [10:0]      out_cell_r, out_cell_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic [CW+10:0]   cell_ext;
  logic             out_free;
  logic             load;

  logic             ram_we;
  logic [AW-1:0]    ram_wa;
  logic [15:0]      ram_wd;
  logic [AW-1:0]    ram_ra;
  logic [15:0]      ram_rd;

  tcce_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  assign exp_pos.idx = CW'(q_data.row) * COLS_C + CW'(q_data.column);
  assign exp_pos.row = RW'(q_data.row);
  assign exp_pos.col = CLW'(q_data.column);
  assign bs_pos      = step_back(cur_r);
  assign sweep_inc   = sweep_r + CW'(1);
  assign copy_src    = sweep_r + COLS_C;
  assign cur_prev    = cur_r.idx - CW'(1);
  assign cell_ext    = {11'b0, cur_r.idx};
  assign out_free    = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcce_pkg::ST_INIT: begin
        if (sweep_r == CELLS_M1_C) state_nxt = tcce_pkg::ST_IDLE;
      end
      tcce_pkg::ST_IDLE: begin
        if (!q_stat.empty) state_nxt = tcce_pkg::ST_EXEC;
      end
      tcce_pkg::ST_EXEC: begin
        case (op_r)
          tcce_pkg::OP_TAB:   state_nxt = tcce_pkg::ST_TAB;
          tcce_pkg::OP_CLEAR: state_nxt = tcce_pkg::ST_CLEAR;
          tcce_pkg::OP_SCROLL: begin
            if (cur_r.idx < CELLS_C) begin
              state_nxt = tcce_pkg::ST_DONE;
            end else if (LAST_START_C == '0) begin
              state_nxt = tcce_pkg::ST_FILL;
            end else begin
              state_nxt = tcce_pkg::ST_COPY_RD;
            end
          end
          tcce_pkg::OP_READ: begin
            state_nxt = (cur_r.idx != '0) ? tcce_pkg::ST_READ_CAP : tcce_pkg::ST_DONE;
          end
          default: state_nxt = tcce_pkg::ST_DONE;
        endcase
      end
      tcce_pkg::ST_TAB: begin
        if (tab_cnt_r == TAB_LAST) state_nxt = tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_CLEAR: begin
        if (sweep_r == CELLS_M1_C) state_nxt = tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_COPY_RD: state_nxt = tcce_pkg::ST_COPY_WR;
      tcce_pkg::ST_COPY_WR: begin
        state_nxt = (sweep_inc == LAST_START_C) ? tcce_pkg::ST_FILL : tcce_pkg::ST_COPY_RD;
      end
      tcce_pkg::ST_FILL: begin
        if (sweep_r == CELLS_M1_C) state_nxt = tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_READ_CAP: state_nxt = tcce_pkg::ST_DONE;
      tcce_pkg::ST_DONE: begin
        if (out_free) state_nxt = tcce_pkg::ST_IDLE;
      end
      default: state_nxt = tcce_pkg::ST_INIT;
    endcase
  end

  // datapath and store controls
  always_comb begin
    cur_nxt      = cur_r;
    tgt_nxt      = tgt_r;
    op_nxt       = op_r;
    char_nxt     = char_r;
    attr_nxt     = attr_r;
    last_nxt     = last_r;
    sweep_nxt    = sweep_r;
    tab_cnt_nxt  = tab_cnt_r;
    out_cell_nxt = out_cell_r;
    out_char_nxt = out_char_r;
    q_pop        = 1'b0;
    load         = 1'b0;
    ram_we       = 1'b0;
    ram_wa       = sweep_r[AW-1:0];
    ram_wd       = '0;
    ram_ra       = cur_prev[AW-1:0];
    case (state_r)
      tcce_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        sweep_nxt = (sweep_r == CELLS_M1_C) ? '0 : sweep_inc;
      end
      tcce_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop    = 1'b1;
          op_nxt   = q_data.op;
          char_nxt = q_data.char_code;
          attr_nxt = (q_data.attribute == 8'h00) ? default_attr_r : q_data.attribute;
          last_nxt = 8'h00;
          tgt_nxt  = q_data.use_cursor ? cur_r : exp_pos;
        end
      end
      tcce_pkg::ST_EXEC: begin
        case (op_r)
          tcce_pkg::OP_PUT: begin
            if (tgt_r.idx < CELLS_C) begin
              ram_we = 1'b1;
              ram_wa = tgt_r.idx[AW-1:0];
              ram_wd = {attr_r, char_r};
            end
            cur_nxt = step_fwd(tgt_r);
          end
          tcce_pkg::OP_NEWLINE: cur_nxt = newline_pos(tgt_r);
          tcce_pkg::OP_BACKSPACE: begin
            if (cur_r.idx != '0) begin
              ram_we  = 1'b1;
              ram_wa  = bs_pos.idx[AW-1:0];
              ram_wd  = {default_attr_r, tcce_pkg::SPACE_CODE};
              cur_nxt = bs_pos;
            end
          end
          tcce_pkg::OP_TAB:    tab_cnt_nxt = '0;
          tcce_pkg::OP_CLEAR:  sweep_nxt = '0;
          tcce_pkg::OP_SCROLL: sweep_nxt = '0;
          default: ;
        endcase
      end
      tcce_pkg::ST_TAB: begin
        cur_nxt     = step_fwd(cur_r);
        tab_cnt_nxt = tab_cnt_r + tcce_pkg::TAB_CNT_W'(1);
      end
      tcce_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wd    = {default_attr_r, tcce_pkg::SPACE_CODE};
        sweep_nxt = sweep_inc;
        if (sweep_r == CELLS_M1_C) cur_nxt = HOME_POS;
      end
      tcce_pkg::ST_COPY_RD: ram_ra = copy_src[AW-1:0];
      tcce_pkg::ST_COPY_WR: begin
        ram_we    = 1'b1;
        ram_wd    = ram_rd;
        sweep_nxt = sweep_inc;
      end
      tcce_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_wd    = FILL_CELL;
        sweep_nxt = sweep_inc;
        if (sweep_r == CELLS_M1_C) cur_nxt = LAST_ROW_POS;
      end
      tcce_pkg::ST_READ_CAP: last_nxt = ram_rd[7:0];
      tcce_pkg::ST_DONE: begin
        if (out_free) begin
          load         = 1'b1;
          out_cell_nxt = cell_ext[10:0];
          out_char_nxt = last_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= tcce_pkg::ST_INIT;
      cur_r          <= HOME_POS;
      sweep_r        <= '0;
      tab_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
      default_attr_r <= tcce_pkg::DEFAULT_ATTR_RESET;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      sweep_r     <= sweep_nxt;
      tab_cnt_r   <= tab_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        default_attr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt_r      <= tgt_nxt;
    op_r       <= op_nxt;
    char_r     <= char_nxt;
    attr_r     <= attr_nxt;
    last_r     <= last_nxt;
    out_cell_r <= out_cell_nxt;
    out_char_r <= out_char_nxt;
  end

  assign init_busy          = (state_r == tcce_pkg::ST_INIT);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.cursor_cell = out_cell_r;
  assign out_ch.last_char   = out_char_r;

  `TCCE_ASSERT_NOW(a_cursor_range, clk, rst_n, 1'b1, cur_r.idx <= CELLS_C)
  `TCCE_ASSERT_NOW(a_cursor_rowcol, clk, rst_n, 1'b1, cur_r.idx == CW'(cur_r.row) * COLS_C + CW'(cur_r.col))
  `TCCE_ASSERT_NOW(a_write_range, clk, rst_n, ram_we, CW'(ram_wa) < CELLS_C)
  `TCCE_ASSERT_NEXT(a_pop_to_exec, clk, rst_n, q_pop, state_r == tcce_pkg::ST_EXEC)

endmodule

[verif/tb_text_console_cursor_engine_unit.sv]
// Testbench for the text console cursor engine: directed table, then random beats vs predictor.
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_unit;

  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;

  localparam logic [2:0] MODE_PUT       = tcce_pkg::MODE_PUT;
  localparam logic [2:0] MODE_BACKSPACE = tcce_pkg::MODE_BACKSPACE;
  localparam logic [2:0] MODE_TAB       = tcce_pkg::MODE_TAB;
  localparam logic [2:0] MODE_CLEAR     = tcce_pkg::MODE_CLEAR;
  localparam logic [2:0] MODE_SCROLL    = tcce_pkg::MODE_SCROLL;
  localparam logic [2:0] MODE_READ      = tcce_pkg::MODE_READ;

  // modes the block treats as no-ops
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  localparam int PHASE_BEATS = 145;
  localparam int CALM_BEATS  = 60;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [2:0] mode;
    logic       use_cursor;
    logic [4:0] row;
    logic [6:0] column;
    logic [7:0] char_code;
    logic [7:0] attribute;
  } cmd_beat_t;

  typedef struct packed {
    logic [10:0] cursor_cell;
    logic [7:0]  last_char;
  } console_result_t;

  typedef struct packed {
    cmd_beat_t       beat;
    logic            known;
    console_result_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{MODE_READ,      1'b1, 5'd0,  7'd0,   8'h00, 8'h00}, 1'b1, '{11'd0,    8'h00}},
    '{'{MODE_BACKSPACE, 1'b1, 5'd0,  7'd0,   8'h00, 8'h00}, 1'b1, '{11'd0,    8'h00}},
    '{'{MODE_PUT,       1'b1, 5'd0,  7'd0,   8'h41, 8'h00}, 1'b1, '{11'd1,    8'h00}},
    '{'{MODE_READ,      1'b1, 5'd0,  7'd0,   8'h00, 8'h00}, 1'b1, '{11'd1,    8'h41}},
    // last cell on screen fills it
    '{'{MODE_PUT,       1'b0, 5'd24, 7'd79,  8'hff, 8'hff}, 1'b1, '{11'd2000, 8'h00}},
    '{'{MODE_PUT,       1'b1, 5'd0,  7'd0,   8'h42, 8'h12}, 1'b1, '{11'd2000, 8'h00}},
    '{'{MODE_READ,      1'b1, 5'd31, 7'd127, 8'hff, 8'hff}, 1'b1, '{11'd2000, 8'hff}},
    '{'{MODE_TAB,       1'b1, 5'd0,  7'd0,   8'h00, 8'h00}, 1'b1, '{11'd2000, 8'h00}},
    '{'{MODE_PUT,       1'b1, 5'd0,  7'd0,   8'd10, 8'h00}, 1'b1, '{11'd2000, 8'h00}},
    '{'{MODE_SCROLL,    1'b1, 5'd0,  7'd0,   8'h00, 8'h00}, 1'b1, '{11'd1920, 8'h00}},
    '{'{MODE_READ,      1'b1, 5'd0,  7'd0,   8'h00, 8'h00}, 1'b1, '{11'd1920, 8'hff}},
    // not full: scroll does nothing
    '{'{MODE_SCROLL,    1'b0, 5'd5,  7'd5,   8'h00, 8'h00}, 1'b1, '{11'd1920, 8'h00}},
    '{'{MODE_PUT,       1'b1, 5'd0,  7'd0,   8'd10, 8'h00}, 1'b1, '{11'd2000, 8'h00}},
    // off-screen puts, newline included
    '{'{MODE_PUT,       1'b0, 5'd25, 7'd0,   8'h55, 8'h01}, 1'b1, '{11'd2000, 8'h00}},
    '{'{MODE_PUT,       1'b0, 5'd31, 7'd127, 8'd10, 8'h01}, 1'b1, '{11'd2000, 8'h00}},
    '{'{MODE_PUT,       1'b0, 5'd0,  7'd80,  8'h33, 8'h01}, 1'b1, '{11'd2000, 8'h00}},
    '{'{MODE_PUT,       1'b0, 5'd3,  7'd7,   8'd10, 8'h00}, 1'b1, '{11'd320,  8'h00}},
    '{'{MODE_PUT,       1'b0, 5'd0,  7'd0,   8'h00, 8'h01}, 1'b1, '{11'd1,    8'h00}},
    '{'{MODE_BACKSPACE, 1'b0, 5'd31, 7'd127, 8'hff, 8'hff}, 1'b1, '{11'd0,    8'h00}},
    '{'{MODE_TAB,       1'b1, 5'd0,  7'd0,   8'h00, 8'h00}, 1'b1, '{11'd4,    8'h00}},
    '{'{MODE_READ,      1'b1, 5'd0,  7'd0,   8'h00, 8'h00}, 1'b0, '{11'd0,    8'h00}},
    '{'{MODE_SPARE_6,   1'b1, 5'd9,  7'd9,   8'h5a, 8'ha5}, 1'b0, '{11'd0,    8'h00}},
    '{'{MODE_PUT,       1'b0, 5'd24, 7'd78,  8'h7e, 8'h00}, 1'b0, '{11'd0,    8'h00}},
    '{'{MODE_TAB,       1'b1, 5'd0,  7'd0,   8'h00, 8'h00}, 1'b0, '{11'd0,    8'h00}},
    '{'{MODE_CLEAR,     1'b1, 5'd0,  7'd0,   8'h00, 8'h00}, 1'b1, '{11'd0,    8'h00}}
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;

  tcce_in_if  in_if();
  tcce_out_if out_if();

  text_console_cursor_engine_unit #(
    .SCREEN_ROWS    (ROWS),
    .SCREEN_COLUMNS (COLS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the console
  logic [15:0] shadow_cells [CELLS];
  int          shadow_cursor;
  logic [7:0]  shadow_dflt_attr;

  console_result_t want_q [$];

  int  n_beats;
  int  n_results;
  int  n_fail;
  int  n_clears;
  int  n_full_scrolls;
  int  n_settings;
  bit  quiet;
  bit  calm;

  function automatic console_result_t console_step(input cmd_beat_t b);
    console_result_t r;
    int          tgt;
    int          nxt;
    logic [7:0]  at;
    r.last_char = 8'h00;
    case (b.mode)
      MODE_PUT: begin
        if (b.use_cursor || (int'(b.row) < ROWS && int'(b.column) < COLS)) begin
          tgt = b.use_cursor ? shadow_cursor : int'(b.row) * COLS + int'(b.column);
          at  = (b.attribute == 8'h00) ? shadow_dflt_attr : b.attribute;
          if (b.char_code == tcce_pkg::NEWLINE_CODE) begin
            nxt = (tgt / COLS + 1) * COLS;
            shadow_cursor = (nxt > CELLS) ? CELLS : nxt;
          end else if (tgt >= CELLS) begin
            shadow_cursor = CELLS;
          end else begin
            shadow_cells[tgt] = {at, b.char_code};
            shadow_cursor = tgt + 1;
          end
        end
      end
      MODE_BACKSPACE: begin
        if (shadow_cursor > 0) begin
          shadow_cursor--;
          shadow_cells[shadow_cursor] = {shadow_dflt_attr, tcce_pkg::SPACE_CODE};
        end
      end
      MODE_TAB: begin
        shadow_cursor += tcce_pkg::TAB_CELLS;
        if (shadow_cursor > CELLS) shadow_cursor = CELLS;
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++)
          shadow_cells[i] = {shadow_dflt_attr, tcce_pkg::SPACE_CODE};
        shadow_cursor = 0;
        n_clears++;
      end
      MODE_SCROLL: begin
        if (shadow_cursor >= CELLS) begin
          for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++)
            shadow_cells[i] = {tcce_pkg::SCROLL_FILL_ATTR, 8'h00};
          shadow_cursor = CELLS - COLS;
          n_full_scrolls++;
        end
      end
      MODE_READ: begin
        if (shadow_cursor > 0 && shadow_cursor <= CELLS)
          r.last_char = shadow_cells[shadow_cursor - 1][7:0];
      end
      default: ;
    endcase
    r.cursor_cell = 11'(shadow_cursor);
    return r;
  endfunction

  function automatic cmd_beat_t pick_beat();
    cmd_beat_t   b;
    int unsigned p;
    p = $urandom_range(0, 99);
    b.mode       = MODE_PUT;
    b.use_cursor = 1'b1;
    b.row        = 5'($urandom_range(0, 31));
    b.column     = 7'($urandom_range(0, 127));
    b.char_code  = 8'($urandom_range(0, 255));
    b.attribute  = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    if (p < 45) begin
      if ($urandom_range(0, 11) == 0) b.char_code = tcce_pkg::NEWLINE_CODE;
    end else if (p < 55) begin
      b.use_cursor = 1'b0;
      b.row        = 5'($urandom_range(0, ROWS - 1));
      b.column     = 7'($urandom_range(0, COLS - 1));
      if ($urandom_range(0, 7) == 0) b.char_code = tcce_pkg::NEWLINE_CODE;
    end else if (p < 60) begin
      // land near the bottom right so the screen fills and scrolls
      b.use_cursor = 1'b0;
      b.row        = 5'(ROWS - 1);
      b.column     = 7'($urandom_range(COLS - 8, COLS - 1));
    end else if (p < 63) begin
      b.use_cursor = 1'b0;
      if ($urandom_range(0, 1) == 1) b.row = 5'($urandom_range(ROWS, 31));
      else b.column = 7'($urandom_range(COLS, 127));
    end else if (p < 71) begin
      b.mode = MODE_BACKSPACE;
    end else if (p < 78) begin
      b.mode = MODE_TAB;
    end else if (p < 86) begin
      b.mode = MODE_SCROLL;
    end else if (p < 96) begin
      b.mode = MODE_READ;
    end else if (p < 98) begin
      b.mode = MODE_CLEAR;
    end else begin
      b.mode = ($urandom_range(0, 1) == 1) ? MODE_SPARE_6 : MODE_SPARE_7;
    end
    return b;
  endfunction

  task automatic send_beat(input cmd_beat_t b, input logic known, input console_result_t res);
    console_result_t pred;
    int              gap;
    gap = 0;
    if (!calm && !quiet && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.mode       <= b.mode;
    in_if.use_cursor <= b.use_cursor;
    in_if.row        <= b.row;
    in_if.column     <= b.column;
    in_if.char_code  <= b.char_code;
    in_if.attribute  <= b.attribute;
    do @(posedge clk); while (!in_if.ready);
    pred = console_step(b);
    want_q.push_back(known ? res : pred);
    n_beats++;
  endtask

  // only while nothing is in flight
  task automatic set_default_attr(input logic [7:0] v);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_dflt_attr = v;
    n_settings++;
  endtask

  // result side back-pressure
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 12) begin
        stall_left = $urandom_range(0, 10);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    console_result_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_results++;
      if (want_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("unexpected result beat: cursor %0d last %02h",
                   out_if.cursor_cell, out_if.last_char);
      end else begin
        w = want_q.pop_front();
        if (out_if.cursor_cell !== w.cursor_cell || out_if.last_char !== w.last_char) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("mismatch on result %0d: expected cursor %0d last %02h, %s",
                     n_results, w.cursor_cell, w.last_char,
                     $sformatf("got cursor %0d last %02h",
                               out_if.cursor_cell, out_if.last_char));
        end
      end
    end
  end

  initial begin : watchdog
    #60_000_000;
    $display("timeout with %0d results still pending", want_q.size());
    $display("[text_console_cursor_engine_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] phase_attr [3];
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = 8'h00;
    in_if.valid      = 1'b0;
    in_if.mode       = MODE_PUT;
    in_if.use_cursor = 1'b0;
    in_if.row        = '0;
    in_if.column     = '0;
    in_if.char_code  = '0;
    in_if.attribute  = '0;
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = 16'h0000;
    shadow_cursor    = 0;
    shadow_dflt_attr = tcce_pkg::DEFAULT_ATTR_RESET;
    n_beats = 0; n_results = 0; n_fail = 0;
    n_clears = 0; n_full_scrolls = 0; n_settings = 1;
    quiet = 1'b0;
    calm  = 1'b0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_beat(DIR_TAB[i].beat, DIR_TAB[i].known, DIR_TAB[i].res);

    phase_attr[0] = 8'h00;
    phase_attr[1] = 8'hff;
    phase_attr[2] = 8'($urandom_range(1, 254));
    for (int ph = 0; ph < 3; ph++) begin
      set_default_attr(phase_attr[ph]);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (k % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (ph == 2 && k >= PHASE_BEATS - CALM_BEATS) calm = 1'b1;
        send_beat(pick_beat(), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (want_q.size() != 0) n_fail++;

    $display("covered %0d command beats under %0d attribute settings: %0d clears, %s",
             n_beats, n_settings, n_clears,
             $sformatf("%0d full scrolls", n_full_scrolls));
    $display("%0d result beats checked, %0d failures", n_results, n_fail);
    if (n_fail == 0) begin
      $display("[text_console_cursor_engine_unit] OK");
    end else begin
      $display("[text_console_cursor_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/tcce_pkg.sv
hdl/tcce_chan_if.sv
hdl/tcce_ram.sv
hdl/tcce_front.sv
hdl/tcce_queue.sv
hdl/tcce_back.sv
hdl/text_console_cursor_engine_unit.sv
verif/tb_text_console_cursor_engine_unit.sv
